/* design/xab_pkg.sv */
// Shared constants, types and coefficient helpers of the XAS ADPCM block encoder.
package xab_pkg;

  localparam int SUBBLOCKS_DEF     = 4;
  localparam int CODED_SAMPLES_DEF = 30;

  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 32;
  localparam int RES_W    = 26;   // Q.6 residual, signed
  localparam int PEAK_W   = 25;   // magnitude of a residual
  localparam int PRED_W   = 25;   // Q.6 prediction, signed
  localparam int QV_W     = 40;   // scaled residual before quantizing
  localparam int REC_W    = 28;   // Q.6 reconstruction, signed

  localparam int FILTER0_LIMIT = 448;   // 7.0 in Q.6
  localparam int HDR_CAP       = 32752;
  localparam int SHIFT_MAX     = 12;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_PEAK,
    ST_DRAIN,
    ST_SEL,
    ST_SHIFT,
    ST_HDR,
    ST_QA,
    ST_QB,
    ST_QC,
    ST_EM_RD,
    ST_EM_CAP,
    ST_EM_OUT
  } state_e;

  function automatic logic signed [7:0] coef_a(input logic [1:0] f);
    logic signed [7:0] c;
    case (f)
      2'd0:    c = 8'sd0;
      2'd1:    c = -8'sd60;
      2'd2:    c = -8'sd115;
      default: c = -8'sd98;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_b(input logic [1:0] f);
    logic signed [7:0] c;
    case (f)
      2'd2:    c = 8'sd52;
      2'd3:    c = 8'sd55;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // Round to a multiple of 16 and cap.
  function automatic logic signed [15:0] header_value(input logic signed [15:0] v);
    logic signed [16:0] t;
    logic signed [16:0] r;
    t = 17'(v) + 17'sd8;
    r = {t[16:4], 4'b0000};
    if (r > 17'(HDR_CAP)) begin
      r = 17'(HDR_CAP);
    end
    return r[15:0];
  endfunction

endpackage

/* design/xas_adpcm_block_encoder_unit.sv */
// Top level of the one-channel XAS 4-bit ADPCM block encoder.
//
// Input channel (s_axis): one item per sample. tdata carries the signed
// 16-bit sample, tuser the opcode (push a sample, or flush a partial block).
// Output channel (m_axis): 32-bit words of the coded block, first stream
// byte in the low eight bits; tlast marks the final word of each block.
//
// A push writes the sample into the sample RAM. When a sub-block of
// CODED_SAMPLES+2 samples is full the sequencer encodes it from the sample
// RAM: header reads, peak pass, drain with filter and shift choice, four
// header bytes, then each quantized sample in the states QA, QB and QC, all
// paced by the one read port of the sample RAM. When the block is complete
// it sends its words, each read byte by byte from the coded-byte RAM. A
// flush pads with the last sample, then encodes and sends.
// The input is held off while a sub-block is encoded or words are sent.
// A stalled receiver holds the word in the output register; the sequencer
// waits on it and takes samples again once the last word is loaded.
// Reset empties the block and drops any pending word; the RAMs need none.
module xas_adpcm_block_encoder_unit #(
  parameter int SUBBLOCKS     = xab_pkg::SUBBLOCKS_DEF,
  parameter int CODED_SAMPLES = xab_pkg::CODED_SAMPLES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  input  logic        s_axis_tuser_i,   // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] word
  output logic        m_axis_tlast_o    // last_word
);

  import xab_pkg::*;

  localparam int SUB_LEN     = CODED_SAMPLES + 2;
  localparam int DATA_BYTES  = (CODED_SAMPLES + 1) / 2;
  localparam int REC_BYTES   = 4 + DATA_BYTES;
  localparam int STORE_BYTES = SUBBLOCKS * REC_BYTES;
  localparam int WORD_COUNT  = (STORE_BYTES + 3) / 4;
  localparam int SAW  = $clog2(SUB_LEN);
  localparam int EAW  = $clog2(STORE_BYTES);
  localparam int SBW  = $clog2(SUBBLOCKS + 1);
  localparam int IW   = $clog2(CODED_SAMPLES);
  localparam int WCW  = $clog2(WORD_COUNT + 1);
  localparam int IDXW = $clog2(4 * WORD_COUNT + 1);
  localparam int OW   = $clog2(REC_BYTES + 1);

  // Sequencer and block position
  state_e                      state_q, state_d;
  logic [SAW-1:0]              pos_q, pos_d;
  logic [SBW-1:0]              sb_q, sb_d;
  logic                        pad_q, pad_d;
  logic signed [SAMPLE_W-1:0]  prev_q, prev_d;

  // Header values and the peak pass
  logic signed [SAMPLE_W-1:0]  s2_q, s2_d, s1_q, s1_d;
  logic signed [SAMPLE_W-1:0]  p1_q, p1_d, p2_q, p2_d;
  logic signed [RES_W-1:0]     res_q [4];
  logic signed [RES_W-1:0]     res_d [4];
  logic                        rv_q, rv_d;
  logic [PEAK_W-1:0]           peak_q [4];
  logic [PEAK_W-1:0]           peak_d [4];
  logic [1:0]                  filter_q, filter_d;
  logic [3:0]                  shift_q, shift_d;
  logic [1:0]                  byte_q, byte_d;
  logic [IW-1:0]               cnt_q, cnt_d;

  // Quantizer
  logic signed [SAMPLE_W-1:0]  d1_q, d1_d, d2_q, d2_d;
  logic signed [PRED_W-1:0]    pred_q, pred_d;
  logic signed [SAMPLE_W-1:0]  x_q, x_d;
  logic signed [SAMPLE_W-1:0]  qs_q, qs_d;
  logic [3:0]                  nib_hi_q, nib_hi_d;

  // Word output
  logic [WCW-1:0]              wcnt_q, wcnt_d;
  logic [IDXW-1:0]             idx_q, idx_d;
  logic [SBW-1:0]              esub_q, esub_d;
  logic [OW-1:0]               eoff_q, eoff_d;
  logic                        zero_q, zero_d;
  logic [WORD_W-1:0]           word_q, word_d;
  logic                        ov_q, ov_d;
  logic [WORD_W-1:0]           od_q, od_d;
  logic                        ol_q, ol_d;

  // RAM ports
  logic                        s_we, s_re;
  logic [SAW-1:0]              s_waddr, s_raddr;
  logic [SAMPLE_W-1:0]         s_wdata, s_rdata;
  logic                        e_we, e_re;
  logic [EAW-1:0]              e_waddr, e_raddr;
  logic [7:0]                  e_wdata, e_rdata;

  xab_ram #(.WIDTH(SAMPLE_W), .DEPTH(SUB_LEN)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  xab_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tlast_o  = ol_q;

  always_comb begin
    logic signed [SAMPLE_W-1:0] xw;
    logic signed [RES_W-1:0]    absr;
    logic [PEAK_W-1:0]          best;
    logic [PEAK_W-6-1:0]        tt;
    logic [14:0]                tc;
    logic [15:0]                bitv;
    logic signed [QV_W-1:0]     out6, scl, ti, qf;
    logic signed [REC_W-1:0]    rec6, rd;
    logic signed [SAMPLE_W-1:0] dv;
    logic [3:0]                 nib;
    logic [EAW-1:0]             base;
    logic                       last_i;
    logic                       out_free;

    state_d  = state_q;
    pos_d    = pos_q;
    sb_d     = sb_q;
    pad_d    = pad_q;
    prev_d   = prev_q;
    s2_d     = s2_q;
    s1_d     = s1_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    rv_d     = 1'b0;
    filter_d = filter_q;
    shift_d  = shift_q;
    byte_d   = byte_q;
    cnt_d    = cnt_q;
    d1_d     = d1_q;
    d2_d     = d2_q;
    pred_d   = pred_q;
    x_d      = x_q;
    qs_d     = qs_q;
    nib_hi_d = nib_hi_q;
    wcnt_d   = wcnt_q;
    idx_d    = idx_q;
    esub_d   = esub_q;
    eoff_d   = eoff_q;
    zero_d   = zero_q;
    word_d   = word_q;
    od_d     = od_q;
    ol_d     = ol_q;

    out_free = !ov_q || m_axis_tready_i;
    ov_d     = ov_q && !m_axis_tready_i;

    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = pos_q;
    s_wdata = prev_q;
    s_raddr = '0;
    e_we    = 1'b0;
    e_re    = 1'b0;
    e_wdata = '0;
    e_raddr = EAW'(int'(esub_q) * REC_BYTES + int'(eoff_q));

    xw     = s_rdata;
    base   = EAW'(int'(sb_q) * REC_BYTES);
    last_i = (cnt_q == IW'(CODED_SAMPLES - 1));
    e_waddr = base;

    // Four predictor lanes on the sample just read
    for (int j = 0; j < 4; j++) begin
      res_d[j] = (RES_W'(xw) <<< 6)
               + RES_W'(coef_a(2'(j))) * RES_W'(p1_q)
               + RES_W'(coef_b(2'(j))) * RES_W'(p2_q);
    end

    // Peak tracking on the registered lane results
    for (int j = 0; j < 4; j++) begin
      peak_d[j] = peak_q[j];
      absr = (res_q[j] < 0) ? -res_q[j] : res_q[j];
      if (rv_q && (peak_q[j] < PEAK_W'(absr))) begin
        peak_d[j] = PEAK_W'(absr);
      end
    end

    // Quantizer, second step
    out6 = (QV_W'(x_q) <<< 6) + QV_W'(pred_q);
    scl  = out6 <<< shift_q;
    ti   = (scl < 0) ? ((scl + QV_W'(63)) >>> 6) : (scl >>> 6);
    qf   = (ti + QV_W'(2048)) >>> 12;

    // Quantizer, third step
    rec6 = (REC_W'(qs_q >>> shift_q) <<< 6) - REC_W'(pred_q);
    rd   = (rec6 < 0) ? ((rec6 + REC_W'(63)) >>> 6) : (rec6 >>> 6);
    if (rd > REC_W'(32767)) begin
      dv = 16'sh7fff;
    end else if (rd < REC_W'(-32768)) begin
      dv = -16'sh8000;
    end else begin
      dv = rd[15:0];
    end
    nib = qs_q[15:12];

    best = '0;
    tt   = '0;
    tc   = '0;
    bitv = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == OP_FLUSH) begin
            // Drop a flush on an empty block
            if ((pos_q != '0) || (sb_q != '0)) begin
              pad_d   = 1'b1;
              state_d = ST_PAD;
            end
          end else begin
            s_we    = 1'b1;
            s_wdata = s_axis_tdata_i;
            prev_d  = s_axis_tdata_i;
            if (pos_q == SAW'(SUB_LEN - 1)) begin
              pos_d   = '0;
              state_d = ST_H0;
            end else begin
              pos_d = pos_q + 1'b1;
            end
          end
        end
      end

      ST_PAD: begin
        s_we = 1'b1;
        if (pos_q == SAW'(SUB_LEN - 1)) begin
          pos_d   = '0;
          state_d = ST_H0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end

      ST_H0: begin
        s_re    = 1'b1;
        s_raddr = SAW'(0);
        state_d = ST_H1;
      end

      ST_H1: begin
        s_re    = 1'b1;
        s_raddr = SAW'(1);
        s2_d    = header_value(xw);
        state_d = ST_H2;
      end

      ST_H2: begin
        s_re    = 1'b1;
        s_raddr = SAW'(2);
        s1_d    = header_value(xw);
        p1_d    = header_value(xw);
        p2_d    = s2_q;
        cnt_d   = '0;
        for (int j = 0; j < 4; j++) begin
          peak_d[j] = '0;
        end
        state_d = ST_PEAK;
      end

      ST_PEAK: begin
        rv_d = 1'b1;
        p2_d = p1_q;
        p1_d = xw;
        if (last_i) begin
          state_d = ST_DRAIN;
        end else begin
          s_re    = 1'b1;
          s_raddr = SAW'(cnt_q) + SAW'(3);
          cnt_d   = cnt_q + 1'b1;
        end
      end

      ST_DRAIN: begin
        state_d = ST_SEL;
      end

      ST_SEL: begin
        // Filter 0 wins outright on a quiet sub-block, else the lowest peak
        filter_d = 2'd0;
        if (peak_q[0] > PEAK_W'(FILTER0_LIMIT)) begin
          best = peak_q[0];
          for (int j = 1; j < 4; j++) begin
            if (peak_q[j] < best) begin
              best     = peak_q[j];
              filter_d = 2'(j);
            end
          end
        end
        state_d = ST_SHIFT;
      end

      ST_SHIFT: begin
        tt = peak_q[filter_q][PEAK_W-1:6];
        tc = (tt > (PEAK_W-6)'(32767)) ? 15'h7fff : tc | tt[14:0];
        shift_d = 4'(SHIFT_MAX);
        for (int s = SHIFT_MAX - 1; s >= 0; s--) begin
          bitv = 16'h4000 >> s;
          if (((16'(tc) + (bitv >> 3)) & bitv) != '0) begin
            shift_d = 4'(s);
          end
        end
        byte_d  = '0;
        state_d = ST_HDR;
      end

      ST_HDR: begin
        e_we    = 1'b1;
        e_waddr = base + EAW'(byte_q);
        case (byte_q)
          2'd0:    e_wdata = s2_q[7:0] | 8'(filter_q);
          2'd1:    e_wdata = s2_q[15:8];
          2'd2:    e_wdata = s1_q[7:0] | 8'(shift_q);
          default: e_wdata = s1_q[15:8];
        endcase
        byte_d = byte_q + 1'b1;
        if (byte_q == 2'd3) begin
          s_re    = 1'b1;
          s_raddr = SAW'(2);
          d1_d    = s1_q;
          d2_d    = s2_q;
          cnt_d   = '0;
          state_d = ST_QA;
        end
      end

      ST_QA: begin
        pred_d  = PRED_W'(coef_a(filter_q)) * PRED_W'(d1_q)
                + PRED_W'(coef_b(filter_q)) * PRED_W'(d2_q);
        x_d     = xw;
        state_d = ST_QB;
      end

      ST_QB: begin
        if (qf > QV_W'(7)) begin
          qs_d = 16'sh7fff;
        end else if (qf < QV_W'(-8)) begin
          qs_d = -16'sh8000;
        end else begin
          qs_d = {qf[3:0], 12'h000};
        end
        state_d = ST_QC;
      end

      ST_QC: begin
        d2_d    = d1_q;
        d1_d    = dv;
        e_waddr = base + EAW'(4) + EAW'(cnt_q >> 1);
        if (cnt_q[0]) begin
          e_we    = 1'b1;
          e_wdata = {nib_hi_q, nib};
        end else if (last_i) begin
          e_we    = 1'b1;
          e_wdata = {nib, 4'h0};
        end else begin
          nib_hi_d = nib;
        end
        if (last_i) begin
          if (sb_q == SBW'(SUBBLOCKS - 1)) begin
            sb_d    = '0;
            wcnt_d  = '0;
            idx_d   = '0;
            esub_d  = '0;
            eoff_d  = '0;
            byte_d  = '0;
            state_d = ST_EM_RD;
          end else begin
            sb_d    = sb_q + 1'b1;
            state_d = pad_q ? ST_PAD : ST_IDLE;
          end
        end else begin
          s_re    = 1'b1;
          s_raddr = SAW'(cnt_q) + SAW'(3);
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_QA;
        end
      end

      ST_EM_RD: begin
        // Headers first, then data bytes column by column across sub-blocks
        e_re   = (idx_q < IDXW'(STORE_BYTES));
        zero_d = !(idx_q < IDXW'(STORE_BYTES));
        idx_d  = idx_q + 1'b1;
        if (idx_q < IDXW'(4 * SUBBLOCKS)) begin
          if (eoff_q == OW'(3)) begin
            if (esub_q == SBW'(SUBBLOCKS - 1)) begin
              esub_d = '0;
              eoff_d = OW'(4);
            end else begin
              esub_d = esub_q + 1'b1;
              eoff_d = '0;
            end
          end else begin
            eoff_d = eoff_q + 1'b1;
          end
        end else begin
          if (esub_q == SBW'(SUBBLOCKS - 1)) begin
            esub_d = '0;
            eoff_d = eoff_q + 1'b1;
          end else begin
            esub_d = esub_q + 1'b1;
          end
        end
        state_d = ST_EM_CAP;
      end

      ST_EM_CAP: begin
        word_d[8*byte_q +: 8] = zero_q ? 8'h00 : e_rdata;
        if (byte_q == 2'd3) begin
          state_d = ST_EM_OUT;
        end else begin
          byte_d  = byte_q + 1'b1;
          state_d = ST_EM_RD;
        end
      end

      ST_EM_OUT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          od_d   = word_q;
          ol_d   = (wcnt_q == WCW'(WORD_COUNT - 1));
          byte_d = '0;
          if (wcnt_q == WCW'(WORD_COUNT - 1)) begin
            pad_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            wcnt_d  = wcnt_q + 1'b1;
            state_d = ST_EM_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      sb_q    <= '0;
      pad_q   <= 1'b0;
      prev_q  <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      sb_q    <= sb_d;
      pad_q   <= pad_d;
      prev_q  <= prev_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q     <= s2_d;
    s1_q     <= s1_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    res_q    <= res_d;
    peak_q   <= peak_d;
    filter_q <= filter_d;
    shift_q  <= shift_d;
    byte_q   <= byte_d;
    cnt_q    <= cnt_d;
    d1_q     <= d1_d;
    d2_q     <= d2_d;
    pred_q   <= pred_d;
    x_q      <= x_d;
    qs_q     <= qs_d;
    nib_hi_q <= nib_hi_d;
    wcnt_q   <= wcnt_d;
    idx_q    <= idx_d;
    esub_q   <= esub_d;
    eoff_q   <= eoff_d;
    zero_q   <= zero_d;
    word_q   <= word_d;
    od_q     <= od_d;
    ol_q     <= ol_d;
  end

  // The block position stays inside the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(pos_q) < SUB_LEN) && (sb_q < SBW'(SUBBLOCKS)))
    else $error("block position out of range");

  // A word loaded into the output register is flagged last only if it ends the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EM_OUT) && (!ov_q || m_axis_tready_i))
      |=> (ol_q == ($past(wcnt_q) == WCW'(WORD_COUNT - 1))))
    else $error("last word flagged wrongly");

  // The coded-byte store is never written while words are sent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_we |-> ((state_q == ST_HDR) || (state_q == ST_QC)))
    else $error("store written outside encoding");

endmodule

/* design/xab_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module xab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
